// File: sv/psg_pkg.sv
// package: shared types and constants of the tone/noise sound generator
package psg_pkg;

    localparam int unsigned PER_W  = 10;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned ATT_W  = 4;
    localparam int unsigned BVOL_W = 9;
    localparam int unsigned NSR_W  = 16;
    localparam int unsigned AMP_W  = ATT_W + BVOL_W;
    localparam int unsigned SUM_W  = 17;
    localparam int unsigned SMP_W  = 16;

    // item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // latch code of the noise control register
    localparam logic [2:0] LATCH_NOISE = 3'd6;

    // noise reload selections
    localparam logic [1:0] NSEL_16  = 2'd0;
    localparam logic [1:0] NSEL_32  = 2'd1;
    localparam logic [1:0] NSEL_64  = 2'd2;
    localparam logic [1:0] NSEL_T2  = 2'd3;

    localparam logic [CNT_W-1:0]  NRELOAD_16 = 11'h010;
    localparam logic [CNT_W-1:0]  NRELOAD_32 = 11'h020;
    localparam logic [CNT_W-1:0]  NRELOAD_64 = 11'h040;
    localparam logic [NSR_W-1:0]  NOISE_SEED = 16'h0001;
    localparam logic [BVOL_W-1:0] BVOL_RST   = 9'd100;
    localparam logic [ATT_W-1:0]  ATT_SILENT = 4'hf;
    // polarity after reset: tones 0 and 2 plus, tone 1 and noise minus
    localparam logic [3:0]        POL_RST    = 4'b0101;

    localparam logic signed [SUM_W-1:0] SMP_MAX = 17'sd32767;
    localparam logic signed [SUM_W-1:0] SMP_MIN = -17'sd32768;

    // channel levels handed from the state stage to the mixer
    typedef struct packed {
        logic                       vld;
        logic [2:0]                 tone_pol;
        logic                       noise_bit;
        logic [3:0][ATT_W-1:0]      att;
        logic [BVOL_W-1:0]          bvol;
    } t_mix_in;

endpackage

// File: sv/psg_if.sv
// interfaces: input item, result sample and configuration write channels
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] write_byte;
    modport source (output valid, output action, output write_byte, input ready);
    modport sink   (input valid, input action, input write_byte, output ready);
endinterface

interface psg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface psg_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] gain;
    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface

// File: sv/psg_tone_noise_generator_top.sv
// top level: three-tone plus noise sound generator with sample output
//
//  channel  dir  payload                        transfer when
//  i_in     in   action, write_byte             valid & ready
//  o_smp    out  sample (signed 16)             valid & ready
//  i_cfg    in   gain (9)                       valid & ready (ready always high)
//
// one item per clock while input ready is high; a tick's sample passes through the
// state register, then the mixer result register
// a write byte produces no sample; it only updates the register file
// reset is synchronous: all attenuations silent, polarities plus/minus/plus/minus
// a stalled sample holds the next tick in the state stage; input ready drops
// only while both a pending tick and a waiting sample are present
module psg_tone_noise_generator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psg_in_if.sink     i_in,
    psg_out_if.source  o_smp,
    psg_cfg_if.sink    i_cfg
);
    import psg_pkg::*;

    t_mix_in mix;
    logic    mix_rdy;

    assign i_cfg.ready = 1'b1;

    psg_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_action     (i_in.action),
        .i_write_byte (i_in.write_byte),
        .o_ready      (i_in.ready),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_bvol   (i_cfg.gain),
        .i_mix_rdy    (mix_rdy),
        .o_mix        (mix)
    );

    psg_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mix     (mix),
        .o_mix_rdy (mix_rdy),
        .o_valid   (o_smp.valid),
        .o_sample  (o_smp.sample),
        .i_ready   (o_smp.ready)
    );

endmodule

// File: sv/psg_core.sv
// register file, down-counters, polarities and noise shift register
module psg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    input  logic [7:0]        i_write_byte,
    output logic              o_ready,
    input  logic              i_cfg_valid,
    input  logic [8:0]        i_cfg_bvol,
    input  logic              i_mix_rdy,
    output psg_pkg::t_mix_in  o_mix
);
    import psg_pkg::*;

    logic [2:0]                    r_latch, n_latch;
    logic [2:0][PER_W-1:0]         r_per, n_per;
    logic [3:0][ATT_W-1:0]         r_att, n_att;
    logic [2:0]                    r_nctl, n_nctl;
    logic [NSR_W-1:0]              r_nsr, n_nsr;
    logic [3:0][CNT_W-1:0]         r_cnt, n_cnt;
    logic [3:0]                    r_pol, n_pol;
    logic                          r_nbit, n_nbit;
    logic [BVOL_W-1:0]             r_bvol;
    logic                          r_mix_vld, n_mix_vld;

    logic                          acc;
    logic                          acc_wr;
    logic                          acc_tick;
    logic [2:0]                    lat;
    logic [3:0][CNT_W-1:0]         reload;
    logic                          fb;

    assign o_ready  = !r_mix_vld || i_mix_rdy;
    assign acc      = i_valid && o_ready;
    assign acc_wr   = acc && (i_action == ACT_WRITE);
    assign acc_tick = acc && (i_action == ACT_TICK);
    assign lat      = i_write_byte[7] ? i_write_byte[6:4] : r_latch;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            reload[i] = {1'b0, r_per[i]};
        end
        case (r_nctl[1:0])
            NSEL_16: reload[3] = NRELOAD_16;
            NSEL_32: reload[3] = NRELOAD_32;
            NSEL_64: reload[3] = NRELOAD_64;
            default: reload[3] = {1'b0, r_per[2]};
        endcase
    end

    assign fb = r_nctl[2] ? (r_nsr[0] ^ r_nsr[3]) : r_nsr[0];

    always_comb begin
        n_latch   = r_latch;
        n_per     = r_per;
        n_att     = r_att;
        n_nctl    = r_nctl;
        n_nsr     = r_nsr;
        n_cnt     = r_cnt;
        n_pol     = r_pol;
        n_nbit    = r_nbit;
        n_mix_vld = r_mix_vld && !i_mix_rdy;
        if (acc_wr) begin
            n_latch = lat;
            if (lat == LATCH_NOISE) begin
                n_nctl = i_write_byte[2:0];
                n_nsr  = NOISE_SEED;
            end else if (lat[0]) begin
                n_att[lat[2:1]] = i_write_byte[3:0];
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (lat[2:1] == 2'(i)) begin
                        if (i_write_byte[7]) begin
                            n_per[i] = {r_per[i][PER_W-1:4], i_write_byte[3:0]};
                        end else begin
                            n_per[i] = {i_write_byte[5:0], r_per[i][3:0]};
                        end
                    end
                end
            end
        end
        if (acc_tick) begin
            n_mix_vld = 1'b1;
            for (int i = 0; i < 4; i++) begin
                // zero or one reloads, so period zero toggles every tick
                if (r_cnt[i] <= CNT_W'(1)) begin
                    n_cnt[i] = reload[i];
                    n_pol[i] = !r_pol[i];
                end else begin
                    n_cnt[i] = r_cnt[i] - CNT_W'(1);
                end
            end
            // noise rising edge: sample then shift
            if (r_cnt[3] <= CNT_W'(1) && !r_pol[3]) begin
                n_nbit = r_nsr[0];
                n_nsr  = {fb, r_nsr[NSR_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= '0;
            r_per     <= '0;
            r_att     <= {4{ATT_SILENT}};
            r_nctl    <= '0;
            r_nsr     <= '0;
            r_cnt     <= '0;
            r_pol     <= POL_RST;
            r_nbit    <= 1'b0;
            r_bvol    <= BVOL_RST;
            r_mix_vld <= 1'b0;
        end else begin
            r_latch   <= n_latch;
            r_per     <= n_per;
            r_att     <= n_att;
            r_nctl    <= n_nctl;
            r_nsr     <= n_nsr;
            r_cnt     <= n_cnt;
            r_pol     <= n_pol;
            r_nbit    <= n_nbit;
            r_mix_vld <= n_mix_vld;
            if (i_cfg_valid) begin
                r_bvol <= i_cfg_bvol;
            end
        end
    end

    assign o_mix.vld       = r_mix_vld;
    assign o_mix.tone_pol  = r_pol[2:0];
    assign o_mix.noise_bit = r_nbit;
    assign o_mix.att       = r_att;
    assign o_mix.bvol      = r_bvol;

    a_write_keeps_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr |=> $stable(r_cnt) && $stable(r_pol))
        else $error("register write moved a counter or polarity");

    a_tick_makes_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_tick |=> r_mix_vld)
        else $error("tick transfer did not raise a pending sample");

    a_pending_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mix_vld && !i_mix_rdy |=> $stable(r_pol) && $stable(r_att) && $stable(r_nbit))
        else $error("channel state changed under a stalled sample");

    a_zero_nsr_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nsr == '0 && !acc_wr |=> r_nsr == '0)
        else $error("noise shift register left zero without a write");

endmodule

// File: sv/psg_mix.sv
// mixer: scales channel levels, sums, saturates and holds the result register
module psg_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psg_pkg::t_mix_in   i_mix,
    output logic               o_mix_rdy,
    output logic               o_valid,
    output logic signed [15:0] o_sample,
    input  logic               i_ready
);
    import psg_pkg::*;

    logic [3:0][AMP_W-1:0]    amp;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sat;
    logic                     r_out_vld;
    logic signed [SMP_W-1:0]  r_sample;
    logic                     load;

    always_comb begin
        // 15 - attenuation is the bitwise inverse
        for (int i = 0; i < 4; i++) begin
            amp[i] = {{BVOL_W{1'b0}}, ~i_mix.att[i]} * AMP_W'(i_mix.bvol);
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (i_mix.tone_pol[i]) begin
                sum = sum + $signed({4'b0, amp[i]});
            end else begin
                sum = sum - $signed({4'b0, amp[i]});
            end
        end
        if (i_mix.noise_bit) begin
            sum = sum + $signed({4'b0, amp[3]});
        end
        if (sum > SMP_MAX) begin
            sat = SMP_MAX;
        end else if (sum < SMP_MIN) begin
            sat = SMP_MIN;
        end else begin
            sat = sum;
        end
    end

    assign o_mix_rdy = !r_out_vld || i_ready;
    assign load      = i_mix.vld && o_mix_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_mix_rdy) begin
            r_out_vld <= i_mix.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sample <= sat[SMP_W-1:0];
        end
    end

    assign o_valid  = r_out_vld;
    assign o_sample = r_sample;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_vld)
        else $error("loaded sample not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_ready |=> $stable(r_sample))
        else $error("waiting sample overwritten");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_mix.att == {4{ATT_SILENT}} |=> r_sample == '0)
        else $error("all channels silent but sample nonzero");

endmodule
